[rtl/r2fft_pkg.sv]
`default_nettype none
package r2fft_pkg;

  localparam int unsigned PointsDefault = 8;
  localparam int unsigned MaxLog2 = 6;
  localparam int unsigned SampleW = 16;
  localparam int unsigned BinW = 24;
  localparam int unsigned CoefW = 16;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_re;
    logic signed [SampleW-1:0] sample_im;
  } sample_t;

  typedef struct packed {
    logic signed [BinW-1:0] bin_re;
    logic signed [BinW-1:0] bin_im;
    logic [5:0]             bin_index;
    logic                   frame_last;
  } bin_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_LO,
    ST_RD_HI,
    ST_MUL,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT
  } fsm_e;

  typedef struct packed {
    logic       load_we;
    logic [5:0] load_addr;
    logic       rd_lo;
    logic       rd_hi;
    logic       mul;
    logic       wr;
    logic       emit_rd;
    logic       emit;
    logic [5:0] lo_addr;
    logic [5:0] hi_addr;
    logic [4:0] tw_idx;
    logic       last;
  } ctrl_t;

  // round(32768*cos(2*pi*m/64)), m = 0..31, saturated at +32767
  function automatic logic signed [CoefW-1:0] cos_lut(input logic [4:0] m);
    logic signed [CoefW-1:0] v;
    case (m)
      5'd0: v = 16'sd32767;   5'd1: v = 16'sd32610;   5'd2: v = 16'sd32138;
      5'd3: v = 16'sd31357;   5'd4: v = 16'sd30274;   5'd5: v = 16'sd28899;
      5'd6: v = 16'sd27246;   5'd7: v = 16'sd25330;   5'd8: v = 16'sd23170;
      5'd9: v = 16'sd20788;   5'd10: v = 16'sd18205;  5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;  5'd13: v = 16'sd9512;   5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;   5'd16: v = 16'sd0;      5'd17: v = -16'sd3212;
      5'd18: v = -16'sd6393;  5'd19: v = -16'sd9512;  5'd20: v = -16'sd12540;
      5'd21: v = -16'sd15447; 5'd22: v = -16'sd18205; 5'd23: v = -16'sd20788;
      5'd24: v = -16'sd23170; 5'd25: v = -16'sd25330; 5'd26: v = -16'sd27246;
      5'd27: v = -16'sd28899; 5'd28: v = -16'sd30274; 5'd29: v = -16'sd31357;
      5'd30: v = -16'sd32138; 5'd31: v = -16'sd32610;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CoefW-1:0] sin_lut(input logic [4:0] m);
    logic [4:0] d;
    d = (m <= 5'd16) ? 5'(5'd16 - m) : 5'(m - 5'd16);
    return cos_lut(d);
  endfunction

endpackage
`default_nettype wire

[rtl/r2fft_ctrl.sv]
`default_nettype none
module r2fft_ctrl #(
  parameter int unsigned POINTS = r2fft_pkg::PointsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output r2fft_pkg::ctrl_t    ctrl_o,
  output logic                busy_o
);
  import r2fft_pkg::*;

  localparam int unsigned LogN = $clog2(POINTS);
  localparam int unsigned AW = (LogN < 1) ? 1 : LogN;

  fsm_e state_q, state_d;
  logic [AW-1:0] load_cnt_q, load_cnt_d;
  logic [2:0]    stage_q, stage_d;    // stage number minus one
  logic [AW-1:0] bfly_q, bfly_d;      // butterfly index within a stage
  logic [AW-1:0] emit_q, emit_d;

  logic [AW-1:0] rev;
  logic [AW:0]   half, mask_lo, pos;
  logic [AW:0]   lo_full, j;
  logic          load_done, bfly_done, stage_done, emit_done;

  always_comb begin
    rev = '0;
    for (int i = 0; i < LogN; i++) rev[LogN-1-i] = load_cnt_q[i];
  end

  // butterfly b in stage s: j = b mod half, group = b div half, lo = group*span + j
  always_comb begin
    half    = (AW+1)'(1) << stage_q;
    mask_lo = half - (AW+1)'(1);
    j       = {1'b0, bfly_q} & mask_lo;
    pos     = (({1'b0, bfly_q} & ~mask_lo) << 1);
    lo_full = pos | j;
  end

  assign load_done  = (load_cnt_q == AW'(POINTS - 1));
  assign bfly_done  = (bfly_q == AW'(POINTS / 2 - 1));
  assign stage_done = (stage_q == 3'(LogN - 1));
  assign emit_done  = (emit_q == AW'(POINTS - 1));

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    stage_d    = stage_q;
    bfly_d     = bfly_q;
    emit_d     = emit_q;
    case (state_q)
      ST_LOAD: if (start_i) begin
        load_cnt_d = load_done ? '0 : AW'(load_cnt_q + 1'b1);
        if (load_done) begin
          state_d = ST_RD_LO;
          stage_d = '0;
          bfly_d  = '0;
        end
      end
      ST_RD_LO: state_d = ST_RD_HI;
      ST_RD_HI: state_d = ST_MUL;
      ST_MUL:   state_d = ST_WR;
      ST_WR: begin
        if (bfly_done) begin
          bfly_d = '0;
          if (stage_done) begin
            state_d = ST_EMIT_RD;
            emit_d  = '0;
          end else begin
            stage_d = 3'(stage_q + 1'b1);
            state_d = ST_RD_LO;
          end
        end else begin
          bfly_d  = AW'(bfly_q + 1'b1);
          state_d = ST_RD_LO;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_done) state_d = ST_LOAD;
        else begin
          emit_d  = AW'(emit_q + 1'b1);
          state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.load_addr = 6'(rev);
    ctrl_o.lo_addr   = 6'(lo_full + half);
    ctrl_o.hi_addr   = 6'(lo_full);
    // twiddle index m = j * (64 >> s)
    ctrl_o.tw_idx    = 5'((6'(j) << (3'd5 - stage_q)));
    ctrl_o.last      = emit_done;
    busy_o = (state_q != ST_LOAD);
    case (state_q)
      ST_LOAD:    ctrl_o.load_we = start_i;
      ST_RD_LO:   ctrl_o.rd_lo   = 1'b1;
      ST_RD_HI:   ctrl_o.rd_hi   = 1'b1;
      ST_MUL:     ctrl_o.mul     = 1'b1;
      ST_WR:      ctrl_o.wr      = 1'b1;
      ST_EMIT_RD: begin
        ctrl_o.emit_rd = 1'b1;
        ctrl_o.hi_addr = 6'(emit_q);
      end
      ST_EMIT: begin
        ctrl_o.emit    = 1'b1;
        ctrl_o.hi_addr = 6'(emit_q);
      end
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      stage_q    <= '0;
      bfly_q     <= '0;
      emit_q     <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      stage_q    <= stage_d;
      bfly_q     <= bfly_d;
      emit_q     <= emit_d;
    end
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_we |-> !busy_o) else $error("load while busy");
  a_emit_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |-> $past(ctrl_o.emit_rd)) else $error("emit without read");
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && start_i && load_done) |=> (state_q == ST_RD_LO && stage_q == 3'd0))
    else $error("frame did not start transform");
endmodule
`default_nettype wire

[rtl/r2fft_dp.sv]
`default_nettype none
module r2fft_dp #(
  parameter int unsigned POINTS = r2fft_pkg::PointsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  r2fft_pkg::ctrl_t      ctrl_i,
  input  r2fft_pkg::sample_t    sample_i,
  output r2fft_pkg::bin_t       bin_o,
  output logic                  bin_valid_o
);
  import r2fft_pkg::*;

  localparam int unsigned AW = ($clog2(POINTS) < 1) ? 1 : $clog2(POINTS);

  logic [2*BinW-1:0] mem_q [POINTS];
  logic [2*BinW-1:0] rd_q;
  logic signed [BinW-1:0] lo_re_q, lo_im_q, hi_re_q, hi_im_q;
  logic signed [CoefW-1:0] c_q, s_q;
  logic signed [BinW+CoefW:0] pr_q, pi_q;
  logic signed [BinW+CoefW:0] pr_d, pi_d;
  logic signed [BinW-1:0] tr, ti;
  logic [AW-1:0] rd_addr;
  logic          bin_valid_q;
  bin_t          bin_q;

  assign rd_addr = ctrl_i.rd_lo ? AW'(ctrl_i.lo_addr) : AW'(ctrl_i.hi_addr);

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (ctrl_i.load_we)
      mem_q[AW'(ctrl_i.load_addr)] <= {BinW'(sample_i.sample_re), BinW'(sample_i.sample_im)};
    else if (ctrl_i.wr) begin
      mem_q[AW'(ctrl_i.lo_addr)] <= {BinW'(hi_re_q - tr), BinW'(hi_im_q - ti)};
      mem_q[AW'(ctrl_i.hi_addr)] <= {BinW'(hi_re_q + tr), BinW'(hi_im_q + ti)};
    end
  end

  // rotate by (c - j*s)
  assign pr_d = (lo_re_q * c_q) + (lo_im_q * s_q);
  assign pi_d = (lo_im_q * c_q) - (lo_re_q * s_q);
  assign tr = BinW'((pr_q + 41'sd16384) >>> 15);
  assign ti = BinW'((pi_q + 41'sd16384) >>> 15);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_hi) begin
      lo_re_q <= rd_q[2*BinW-1:BinW];
      lo_im_q <= rd_q[BinW-1:0];
      c_q     <= cos_lut(ctrl_i.tw_idx);
      s_q     <= sin_lut(ctrl_i.tw_idx);
    end
    if (ctrl_i.mul) begin
      hi_re_q <= rd_q[2*BinW-1:BinW];
      hi_im_q <= rd_q[BinW-1:0];
      pr_q    <= pr_d;
      pi_q    <= pi_d;
    end
    if (ctrl_i.emit) begin
      bin_q.bin_re     <= rd_q[2*BinW-1:BinW];
      bin_q.bin_im     <= rd_q[BinW-1:0];
      bin_q.bin_index  <= ctrl_i.hi_addr;
      bin_q.frame_last <= ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bin_valid_q <= 1'b0;
    else         bin_valid_q <= ctrl_i.emit;
  end

  assign bin_o       = bin_q;
  assign bin_valid_o = bin_valid_q;

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_valid_o && bin_o.frame_last) |-> (bin_o.bin_index == 6'(POINTS - 1)))
    else $error("last flag on wrong bin");
  a_no_wr_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.wr && ctrl_i.load_we)) else $error("write conflict");
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o |=> !bin_valid_o) else $error("back to back bins");
endmodule
`default_nettype wire

[rtl/radix2_dit_fft.sv]
// Channel   Ports                          Handshake
// sample    start_i, sample_i (sample_t)   taken when start_i && !busy_o
// bin       bin_valid_o, bin_o (bin_t)     a pulse per bin, receiver cannot stall
//
// Each sample is stored at its bit-reversed address.
// The last sample of a frame starts the transform: one shared butterfly unit
// runs POINTS/2*log2(POINTS) butterflies, each through RD_LO, RD_HI, MUL and WR,
// then EMIT_RD and EMIT for each of POINTS bins; busy_o stays high throughout.
// Reset clears the controller; the sample store needs no clearing.
`default_nettype none
module radix2_dit_fft #(
  parameter int unsigned POINTS = r2fft_pkg::PointsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  r2fft_pkg::sample_t  sample_i,
  output logic                busy_o,
  output logic                bin_valid_o,
  output r2fft_pkg::bin_t     bin_o
);
  import r2fft_pkg::*;

  ctrl_t ctrl;

  // sequence loads, butterflies and readout
  r2fft_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  // hold the frame, rotate and combine
  r2fft_dp #(.POINTS(POINTS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .sample_i   (sample_i),
    .bin_o      (bin_o),
    .bin_valid_o(bin_valid_o)
  );

  a_no_bin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o |-> $past(busy_o)) else $error("bin while idle");
endmodule
`default_nettype wire

[verif/radix2_dit_fft_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module radix2_dit_fft_tb;
  import r2fft_pkg::*;

  localparam int unsigned NPts = PointsDefault;
  localparam int unsigned Stages = $clog2(NPts);
  // Worst frame: all butterflies and bins, plus loading.
  localparam int unsigned FrameCycles = 4 * (NPts / 2) * Stages + 2 * NPts + 8;
  localparam int unsigned RandomItems = 320;
  localparam longint unsigned CycleLimit = 64'd400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  sample_t sample_i = '0;
  logic busy_o;
  logic bin_valid_o;
  bin_t bin_o;

  radix2_dit_fft #(.POINTS(NPts)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .sample_i   (sample_i),
    .busy_o     (busy_o),
    .bin_valid_o(bin_valid_o),
    .bin_o      (bin_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pending samples with the gap to wait before each; gap < 0 means
  // hold until every expected bin has arrived.
  sample_t pend_q[$];
  int      gap_q[$];
  bin_t    bins_q[$];

  // Predictor state: frame store and arrival count.
  logic signed [BinW-1:0] frame_re [NPts];
  logic signed [BinW-1:0] frame_im [NPts];
  int unsigned fill_cnt = 0;

  bit failed = 1'b0;
  bit stim_done = 1'b0;
  longint unsigned cycle_cnt = 0;

  function automatic logic signed [BinW-1:0] twiddle_round(input longint prod);
    // Round to nearest, ties toward +inf, with an arithmetic shift.
    return BinW'((prod + 64'sd16384) >>> 15);
  endfunction

  function automatic int unsigned bitrev_pos(input int unsigned v);
    int unsigned r;
    r = 0;
    for (int i = 0; i < Stages; i++) r |= ((v >> i) & 1) << (Stages - 1 - i);
    return r;
  endfunction

  // Own cosine table, Q1.15 rounded, saturated at +32767.
  function automatic int cos_tab(input int unsigned m);
    real x;
    int v;
    x = $cos(6.283185307178 * m / 64.0) * 32768.0;
    v = (x >= 0.0) ? int'($floor(x + 0.5)) : -int'($floor(-x + 0.5));
    return (v > 32767) ? 32767 : v;
  endfunction

  // Store one accepted sample; on the last of a frame run the transform
  // and queue all bins.
  task automatic predict_bins(input sample_t s);
    int unsigned pos, span, half, m, lo;
    longint c, sn, ar, ai;
    logic signed [BinW-1:0] tr, ti, ur, ui;
    bin_t b;
    pos = bitrev_pos(fill_cnt);
    frame_re[pos] = BinW'(s.sample_re);
    frame_im[pos] = BinW'(s.sample_im);
    if (fill_cnt + 1 < NPts) begin
      fill_cnt++;
      return;
    end
    fill_cnt = 0;
    for (int st = 1; st <= Stages; st++) begin
      span = 1 << st;
      half = span >> 1;
      for (int j = 0; j < half; j++) begin
        m = (j * (64 >> st)) & 31;
        c = longint'(cos_tab(m));
        sn = longint'(cos_tab((m <= 16) ? 16 - m : m - 16));
        for (int i = j; i + half < NPts; i += span) begin
          lo = i + half;
          ar = longint'(frame_re[lo]);
          ai = longint'(frame_im[lo]);
          tr = twiddle_round(ar * c + ai * sn);
          ti = twiddle_round(ai * c - ar * sn);
          ur = frame_re[i];
          ui = frame_im[i];
          frame_re[lo] = ur - tr;
          frame_im[lo] = ui - ti;
          frame_re[i] = ur + tr;
          frame_im[i] = ui + ti;
        end
      end
    end
    for (int k = 0; k < NPts; k++) begin
      b.bin_re = frame_re[k];
      b.bin_im = frame_im[k];
      b.bin_index = 6'(k);
      b.frame_last = (k == NPts - 1);
      bins_q.push_back(b);
    end
  endtask

  // Driver: count down the gap, then present the item until it is taken.
  int wait_cnt = 0;
  bit have_item = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        // item is taken at the coming rising edge; sampled by the monitor
      end
      if (!have_item && pend_q.size() > 0) begin
        have_item = 1'b1;
        wait_cnt = gap_q.pop_front();
      end
      if (have_item && start_i) begin
        // hold until accepted
      end else if (have_item) begin
        if (wait_cnt < 0) begin
          if (bins_q.size() == 0 && !busy_o) wait_cnt = 0;
        end else if (wait_cnt > 0) begin
          wait_cnt--;
        end else begin
          sample_i <= pend_q[0];
          start_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: check bins, record accepted items at the rising edge.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && bin_valid_o) begin
      if (bins_q.size() == 0) begin
        $display("%0t: unexpected bin: expected none actual %p", $time, bin_o);
        failed = 1'b1;
      end else begin
        bin_t e;
        e = bins_q.pop_front();
        if (bin_o.bin_re !== e.bin_re || bin_o.bin_im !== e.bin_im ||
            bin_o.bin_index !== e.bin_index || bin_o.frame_last !== e.frame_last) begin
          $display("%0t: bin mismatch: expected %p actual %p", $time, e, bin_o);
          failed = 1'b1;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      predict_bins(sample_i);
      void'(pend_q.pop_front());
      have_item = 1'b0;
      // drop start; the driver raises it again if the next item has no gap
      start_i <= 1'b0;
    end
  end

  task automatic add_item(input logic [15:0] re, input logic [15:0] im, input int gap);
    sample_t s;
    s.sample_re = re;
    s.sample_im = im;
    pend_q.push_back(s);
    gap_q.push_back(gap);
  endtask

  initial begin
    int g;
    // Directed frames: full-scale extremes and an impulse.
    for (int k = 0; k < NPts; k++) add_item(16'h8000, 16'h7fff, 0);
    for (int k = 0; k < NPts; k++) add_item(16'h7fff, 16'h8000, 0);
    for (int k = 0; k < NPts; k++) add_item(k == 0 ? 16'h7fff : 16'h0, 16'h0, 1);
    // Random part, gap zero for a third of items or more, so back-to-back loads occur.
    for (int n = 0; n < RandomItems; n++) begin
      g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      if (n == RandomItems / 2) g = -1;
      case ($urandom_range(0, 5))
        0: add_item(16'h8000, 16'h8000, g);
        1: add_item(16'h7fff, 16'h7fff, g);
        default: add_item(16'($urandom), 16'($urandom), g);
      endcase
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (pend_q.size() == 0);
    wait (bins_q.size() == 0);
    repeat (FrameCycles) @(posedge clk_i);
    stim_done = 1'b1;
    if (!failed && bins_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (!stim_done && cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
`default_nettype wire
